// ===== hw/rtl/ntc_pkg.sv =====
// Package for numeric_type_coercion: type codes, NA patterns, warning bits
// and the double/int conversion helpers. No dependencies.
`default_nettype none
package ntc_pkg;
    localparam logic [2:0] TY_LGL  = 3'd0;
    localparam logic [2:0] TY_INT  = 3'd1;
    localparam logic [2:0] TY_REAL = 3'd2;
    localparam logic [2:0] TY_CPLX = 3'd3;
    localparam logic [2:0] TY_BYTE = 3'd4;

    localparam logic [2:0] SOURCE_TYPE_RESET = TY_INT;
    localparam logic [2:0] TARGET_TYPE_RESET = TY_REAL;

    localparam logic       CFG_SOURCE = 1'b0;
    localparam logic       CFG_TARGET = 1'b1;

    localparam logic [31:0] NA_INT  = 32'h8000_0000;
    localparam logic [63:0] NA_REAL = 64'h7FF0_0000_0000_07A2;

    localparam logic [3:0] WB_INT_NA = 4'b0010;
    localparam logic [3:0] WB_IMAG   = 4'b0100;
    localparam logic [3:0] WB_BYTE   = 4'b1000;

    typedef struct packed {
        logic        nan;
        logic        zero;
        logic        neg;
        logic [10:0] expo;
        logic [51:0] frac;
    } dbl_info_t;

    function automatic dbl_info_t dbl_info(input logic [63:0] b);
        dbl_info_t r;
        r.neg  = b[63];
        r.expo = b[62:52];
        r.frac = b[51:0];
        r.nan  = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
        r.zero = (b[62:0] == 63'd0);
        return r;
    endfunction

    // Exact signed 32-bit integer to double.
    function automatic logic [63:0] int_to_dbl(input logic [31:0] x);
        logic [31:0] mag;
        logic [4:0]  msb;
        logic [51:0] frac;
        logic [63:0] sh;
        mag = x[31] ? (~x + 32'd1) : x;
        msb = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (mag[i])
            begin
                msb = 5'(i);
            end
        end
        sh = {32'd0, mag} << (6'd52 - {1'b0, msb});
        frac = sh[51:0];
        if (mag == 32'd0)
        begin
            return 64'd0;
        end
        return {x[31], 11'(11'd1023 + {6'd0, msb}), frac};
    endfunction

    // Truncate |d| toward zero; valid when exponent < 31 biased-unbiased.
    // Returns magnitude, caller handles range.
    function automatic logic [31:0] dbl_trunc_mag(input logic [63:0] b);
        logic [10:0] e;
        logic [83:0] m;
        e = b[62:52];
        m = {31'd0, 1'b1, b[51:0]};
        if (e < 11'd1023)
        begin
            return 32'd0;
        end
        m = m << (e - 11'd1023);
        return m[83:52];
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/numeric_type_coercion.sv =====
// Element type converter for logical, integer, real, complex and byte vectors.
// Uses ntc_pkg for type codes, NA patterns and conversion helpers.
//
// One element per clock while the output is not stalled: an input register,
// one pass of conversion logic and a result register. Throughput is one
// transfer per cycle when m_tready stays high. The conversion logic (int to
// double normalize, double to int shift) sets the clock limit. The output
// stage holds a stalled result while the input register takes a new element
// only if it is empty.
`default_nettype none
module numeric_type_coercion
    import ntc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [2:0]   cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [63:0] value_bits, [127:64] imag_bits
    input  wire logic [127:0] s_tdata,
    // [0] start_of_vector
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [63:0] result_bits, [127:64] result_imag_bits, [131:128] item_warnings,
    // [135:132] all_warnings, [136] unsupported_pair, [143:137] zero
    output logic [143:0]      m_tdata
);
    logic [2:0] src_reg, tgt_reg;
    logic       in_valid_reg;
    logic [63:0] v_reg, im_reg;
    logic       sov_reg;
    logic       out_valid_reg;
    logic [136:0] out_reg;
    logic [3:0] sticky_reg, sticky_next;

    logic [63:0] res, rim;
    logic [3:0]  w;
    logic        ok;
    logic        adv, take;

    assign cfg_ready = 1'b1;
    assign adv  = !out_valid_reg || m_tready;
    assign s_tready = adv || !in_valid_reg;
    assign take = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= SOURCE_TYPE_RESET;
            tgt_reg <= TARGET_TYPE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_SOURCE)
            begin
                src_reg <= cfg_data;
            end
            else
            begin
                tgt_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sticky_reg    <= 4'd0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (adv)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    sticky_reg <= sticky_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            v_reg   <= s_tdata[63:0];
            im_reg  <= s_tdata[127:64];
            sov_reg <= s_tuser;
        end
        if (adv && in_valid_reg)
        begin
            out_reg <= {!ok, sticky_next, w, rim, res};
        end
    end

    // Conversion logic
    dbl_info_t re, ie;
    logic [31:0] u32, rmag, rint;
    logic [7:0]  byt;
    logic        cnan, re_ovf, re_byte_bad;

    always_comb
    begin
        re = dbl_info(v_reg);
        ie = dbl_info(im_reg);
        u32 = v_reg[31:0];
        byt = v_reg[7:0];
        cnan = re.nan || ie.nan;
        rmag = dbl_trunc_mag(v_reg);
        rint = re.neg ? (~rmag + 32'd1) : rmag;
        // |re| >= 2^31 (infinity included)
        re_ovf = re.expo >= 11'd1054;
        // NaN, <= -1 or >= 256
        re_byte_bad = re.nan || (re.neg && re.expo >= 11'd1023) ||
                      (!re.neg && re.expo >= 11'd1031);
        ok = (src_reg <= TY_BYTE) && (tgt_reg <= TY_BYTE) && (src_reg != tgt_reg);
        res = 64'd0;
        rim = 64'd0;
        w = 4'd0;
        if (ok)
        begin
            case (tgt_reg)
                TY_LGL:
                begin
                    case (src_reg)
                        TY_INT:  res = (u32 == NA_INT) ? {32'd0, NA_INT} : {63'd0, u32 != 0};
                        TY_REAL: res = re.nan ? {32'd0, NA_INT} : {63'd0, !re.zero};
                        TY_CPLX: res = cnan ? {32'd0, NA_INT} :
                                       {63'd0, !re.zero || !ie.zero};
                        default: res = {63'd0, byt != 8'd0};
                    endcase
                end
                TY_INT:
                begin
                    case (src_reg)
                        TY_LGL:  res = {32'd0, u32};
                        TY_BYTE: res = {56'd0, byt};
                        default:
                        begin
                            if (re.nan || (src_reg == TY_CPLX && cnan))
                            begin
                                res = {32'd0, NA_INT};
                            end
                            else if (re_ovf)
                            begin
                                res = {32'd0, NA_INT};
                                w = WB_INT_NA;
                            end
                            else
                            begin
                                res = {32'd0, rint};
                                if (src_reg == TY_CPLX && !ie.zero)
                                begin
                                    w = WB_IMAG;
                                end
                            end
                        end
                    endcase
                end
                TY_REAL:
                begin
                    case (src_reg)
                        TY_LGL, TY_INT:
                            res = (u32 == NA_INT) ? NA_REAL : int_to_dbl(u32);
                        TY_CPLX:
                        begin
                            if (cnan)
                            begin
                                res = NA_REAL;
                            end
                            else
                            begin
                                res = v_reg;
                                if (!ie.zero)
                                begin
                                    w = WB_IMAG;
                                end
                            end
                        end
                        default: res = int_to_dbl({24'd0, byt});
                    endcase
                end
                TY_CPLX:
                begin
                    case (src_reg)
                        TY_LGL, TY_INT:
                        begin
                            if (u32 == NA_INT)
                            begin
                                res = NA_REAL;
                                rim = NA_REAL;
                            end
                            else
                            begin
                                res = int_to_dbl(u32);
                            end
                        end
                        TY_REAL: res = v_reg;
                        default: res = int_to_dbl({24'd0, byt});
                    endcase
                end
                default:
                begin
                    case (src_reg)
                        TY_LGL:
                        begin
                            if (u32 == NA_INT)
                            begin
                                w = WB_BYTE;
                            end
                            else
                            begin
                                res = {56'd0, byt};
                            end
                        end
                        TY_INT:
                        begin
                            if (u32[31:8] != 24'd0)
                            begin
                                w = WB_BYTE;
                            end
                            else
                            begin
                                res = {56'd0, byt};
                            end
                        end
                        default:
                        begin
                            if (re_byte_bad || (src_reg == TY_CPLX && cnan))
                            begin
                                w = WB_BYTE;
                            end
                            else
                            begin
                                res = {56'd0, rmag[7:0]};
                                if (src_reg == TY_CPLX && !ie.zero)
                                begin
                                    w = WB_IMAG;
                                end
                            end
                        end
                    endcase
                end
            endcase
        end
        sticky_next = (sov_reg ? 4'd0 : sticky_reg) | w;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg};

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_sticky_cover: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[135:132] & m_tdata[131:128]) == m_tdata[131:128]))
        else $error("sticky misses item warnings");
    a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[136] |-> m_tdata[131:0] == 132'd0)
        else $error("unsupported pair gave data");
endmodule
`default_nettype wire
